FILE: sv/pss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the packet slot scheduler: request and
// result payloads, configuration view, controller states and commands.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Sizes of the slot table and of the packet type space.
  localparam int MAX_SLOTS  = 8;
  localparam int TYPE_COUNT = 8;

  localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);
  localparam int SLOT_REGS   = (MAX_SLOTS + 1) / 2;
  localparam int SLOT_SEL_W  = (SLOT_REGS > 1) ? $clog2(SLOT_REGS) : 1;
  localparam int TYPE_W      = 3;
  localparam int COUNT_W     = 8;
  localparam int SLOT_W      = 12;
  localparam int SLOT_PAIR_W = 2 * SLOT_W;
  localparam int LEN_W       = 4;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SLOT_LENGTH = 3'd0;
  localparam logic [2:0] REG_SLOTS_A     = 3'd1;
  localparam logic [2:0] REG_SLOTS_B     = 3'd2;
  localparam logic [2:0] REG_SLOTS_C     = 3'd3;
  localparam logic [2:0] REG_SLOTS_D     = 3'd4;

  // Command codes of a request.
  localparam logic CMD_SEND    = 1'b0;
  localparam logic CMD_ENQUEUE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [TYPE_W-1:0] request_type;
  } in_t;

  typedef struct packed {
    logic [TYPE_W-1:0] chosen_type;
    logic              from_queue;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]                      slot_length;
    logic [SLOT_REGS-1:0][SLOT_PAIR_W-1:0] slots;
  } cfg_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage
`default_nettype wire

FILE: sv/pss_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_regs
// Configuration register file behind the APB-style port: slot length and
// four packed slot-pair registers, with read back.
// ----------------------------------------------------------------------------
module pss_regs
  import pss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_length <= LEN_W'(1);
      cfg.slots       <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLOT_LENGTH: cfg.slot_length <= pwdata[LEN_W-1:0];
        REG_SLOTS_A:     cfg.slots[0]    <= pwdata[SLOT_PAIR_W-1:0];
        REG_SLOTS_B:     cfg.slots[1]    <= pwdata[SLOT_PAIR_W-1:0];
        REG_SLOTS_C:     cfg.slots[2]    <= pwdata[SLOT_PAIR_W-1:0];
        REG_SLOTS_D:     cfg.slots[3]    <= pwdata[SLOT_PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back mux.
  always_comb begin
    case (reg_idx)
      REG_SLOT_LENGTH: prdata = DATA_W'(cfg.slot_length);
      REG_SLOTS_A:     prdata = DATA_W'(cfg.slots[0]);
      REG_SLOTS_B:     prdata = DATA_W'(cfg.slots[1]);
      REG_SLOTS_C:     prdata = DATA_W'(cfg.slots[2]);
      REG_SLOTS_D:     prdata = DATA_W'(cfg.slots[3]);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/pss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ctrl
// Controller: takes a request when idle, executes it in the datapath in
// its single execute state, then returns to idle.
// ----------------------------------------------------------------------------
module pss_ctrl
  import pss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output ctrl_t     ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy      = 1'b0;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.load = start;
      end
      S_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The execute state is always followed by idle.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_IDLE))
    else $error("controller stayed in execute");

  // An accepted request is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ctrl.exec)
    else $error("accepted request not executed");
`endif

endmodule
`default_nettype wire

FILE: sv/pss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_datapath
// Scheduler state and arithmetic: pending set, slot index, repeat counter,
// lowest-pending priority encoder and the result register.
// ----------------------------------------------------------------------------
module pss_datapath
  import pss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctrl_t ctrl,
  input  wire in_t   job,
  input  wire cfg_t  cfg,
  output out_t       result,
  output logic       result_strobe
);

  in_t                   job_q;
  logic [TYPE_COUNT-1:0] pending_mask;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [COUNT_W-1:0]    repeat_counter;

  logic [SLOT_PAIR_W-1:0] pair;
  logic [SLOT_W-1:0]      slot;
  logic [TYPE_W-1:0]      own_type;
  logic [COUNT_W-1:0]     count;
  logic                   queue_ok;
  logic [TYPE_W-1:0]      low_type;
  logic                   take_queue;
  logic [COUNT_W:0]       next_count;
  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       next_index;
  logic [TYPE_COUNT-1:0]  pending_next;
  logic [SLOT_IDX_W-1:0]  slot_index_next;
  logic [COUNT_W-1:0]     repeat_counter_next;

  // Current slot fields.
  always_comb begin
    pair     = cfg.slots[SLOT_SEL_W'(slot_index >> 1)];
    slot     = slot_index[0] ? pair[SLOT_PAIR_W-1:SLOT_W] : pair[SLOT_W-1:0];
    own_type = slot[2:0];
    count    = slot[10:3];
    queue_ok = slot[11];
  end

  // Lowest pending type.
  always_comb begin
    low_type = '0;
    for (int i = TYPE_COUNT - 1; i >= 0; i--) begin
      if (pending_mask[i]) begin
        low_type = TYPE_W'(i);
      end
    end
    take_queue = queue_ok && (pending_mask != '0);
  end

  // Repeat counter and slot index advance; length is clamped to 1..MAX_SLOTS.
  always_comb begin
    next_count = {1'b0, repeat_counter} + (COUNT_W + 1)'(1);
    if (cfg.slot_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(cfg.slot_length) > MAX_SLOTS) begin
      eff_len = LEN_W'(MAX_SLOTS);
    end else begin
      eff_len = cfg.slot_length;
    end
    next_index = LEN_W'(slot_index) + LEN_W'(1);
    if (next_count < {1'b0, count}) begin
      repeat_counter_next = next_count[COUNT_W-1:0];
      slot_index_next     = slot_index;
    end else begin
      repeat_counter_next = '0;
      slot_index_next     = (next_index >= eff_len) ? '0 : next_index[SLOT_IDX_W-1:0];
    end
  end

  // Pending set update for either command.
  always_comb begin
    pending_next = pending_mask;
    if (job_q.command == CMD_ENQUEUE) begin
      if (int'(job_q.request_type) < TYPE_COUNT) begin
        pending_next[job_q.request_type] = 1'b1;
      end
    end else if (take_queue) begin
      pending_next[low_type] = 1'b0;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      job_q <= job;
    end
  end

  // Scheduler state and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask   <= '0;
      slot_index     <= '0;
      repeat_counter <= '0;
      result_strobe  <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (ctrl.exec) begin
        pending_mask <= pending_next;
        if (job_q.command == CMD_SEND) begin
          slot_index     <= slot_index_next;
          repeat_counter <= repeat_counter_next;
          result_strobe  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      result.chosen_type <= take_queue ? low_type : own_type;
      result.from_queue  <= take_queue;
    end
  end

`ifndef SYNTHESIS
  // A result follows only the execution of a send request.
  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(ctrl.exec) && ($past(job_q.command) == CMD_SEND)))
    else $error("result without a send request");

  // A type served from the queue is no longer pending.
  a_queue_cleared: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.from_queue) |-> !pending_mask[result.chosen_type])
    else $error("served type still pending");
`endif

endmodule
`default_nettype wire

FILE: sv/packet_slot_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_slot_scheduler_unit
// Picks the next radio packet type from a configured slot sequence or from
// the set of pending queued types.
//
//   Channel   Ports                                   Direction
//   request   start, busy, job (command, request_type) in
//   result    result_strobe, result (chosen_type,      out
//             from_queue)
//   config    psel, penable, pwrite, paddr, pwdata,    in/out
//             prdata, pready
//
// A request is taken when start is high and busy is low; busy then stays
// high for one cycle, so a new request is not taken while the last one
// executes. This is set by the controller's single execute state.
// A send request gives its result after its execute state, for one cycle.
// An enqueue gives no result. The receiver cannot stall the block.
// Synchronous reset clears the pending set, slot index and repeat counter.
// ----------------------------------------------------------------------------
module packet_slot_scheduler_unit
  import pss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               job,
  output out_t                   result,
  output logic                   result_strobe,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t  cfg;
  ctrl_t ctrl;

  pss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  pss_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .job           (job),
    .cfg           (cfg),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packet_slot_scheduler_unit. Send and enqueue
// requests go in over the start/busy handshake, the slot table is set up
// over the APB port, and each strobed result is compared with a local
// model of the slot walk and the pending set. A short directed table comes
// first, then phases of random requests, each under a fresh slot table.
// ----------------------------------------------------------------------------
module tb
  import pss_pkg::*;
();

  // Register indexes past the end of the list; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 125;

  // One line of the directed table: either a register write or a request.
  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    in_t         item;
    bit          pinned;
    out_t        want;
  } row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  in_t               job;
  out_t              result;
  logic              result_strobe;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Model of the scheduler: configuration and walk state.
  logic [LEN_W-1:0]       len_cfg;
  logic [SLOT_PAIR_W-1:0] slot_pairs [SLOT_REGS];
  logic [7:0]             pend_types;
  logic [2:0]             cur_slot;
  logic [7:0]             serve_count;

  out_t expected_types[$];
  row_t directed_rows[$];
  bit   pin_valid;
  out_t pin_value;
  int   mismatch_count;
  int   cycle_count;

  packet_slot_scheduler_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .job           (job),
    .result        (result),
    .result_strobe (result_strobe),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void sched_reset();
    len_cfg     = 4'd1;
    pend_types  = '0;
    cur_slot    = '0;
    serve_count = '0;
    for (int i = 0; i < SLOT_REGS; i++) slot_pairs[i] = '0;
  endfunction

  function automatic void sched_write(input logic [2:0] idx, input logic [31:0] data);
    if (idx == REG_SLOT_LENGTH)
      len_cfg = data[LEN_W-1:0];
    else if (idx >= REG_SLOTS_A && idx <= REG_SLOTS_D)
      slot_pairs[idx - REG_SLOTS_A] = data[SLOT_PAIR_W-1:0];
  endfunction

  // Applies one request to the model; a send yields the type to transmit.
  function automatic bit sched_step(input in_t j, output out_t pick);
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic [8:0]         next_count;
    logic [3:0]         next_slot;
    logic [3:0]         eff_len;
    int                 t;
    pick = '0;
    if (j.command == CMD_ENQUEUE) begin
      pend_types[j.request_type] = 1'b1;
      return 1'b0;
    end
    slot  = cur_slot[0] ? slot_pairs[cur_slot >> 1][2*SLOT_W-1:SLOT_W]
                        : slot_pairs[cur_slot >> 1][SLOT_W-1:0];
    count = slot[10:3];
    if (slot[11] && pend_types != '0) begin
      t = 0;
      while (t < TYPE_COUNT - 1 && !pend_types[t]) t++;
      pick.chosen_type = t[TYPE_W-1:0];
      pick.from_queue  = 1'b1;
      pend_types[t]    = 1'b0;
    end else begin
      pick.chosen_type = slot[2:0];
      pick.from_queue  = 1'b0;
    end
    // Advance the repeat counter; a zero count behaves as one.
    next_count = {1'b0, serve_count} + 9'd1;
    if (next_count < {1'b0, count}) begin
      serve_count = next_count[7:0];
    end else begin
      serve_count = '0;
      eff_len     = (len_cfg == 0) ? 4'd1 : (len_cfg > MAX_SLOTS) ? 4'(MAX_SLOTS) : len_cfg;
      next_slot   = {1'b0, cur_slot} + 4'd1;
      cur_slot    = (next_slot >= eff_len) ? 3'd0 : next_slot[2:0];
    end
    return 1'b1;
  endfunction

  // Model update and result check, both at the rising edge.
  always @(posedge clk) begin : scoreboard
    out_t pick;
    out_t want;
    if (rst) begin
      sched_reset();
    end else begin
      if (psel && penable && pwrite && pready)
        sched_write(paddr[ADDR_W-1:2], pwdata);
      if (start && !busy) begin
        if (sched_step(job, pick))
          expected_types.push_back(pin_valid ? pin_value : pick);
      end
      if (result_strobe === 1'b1) begin
        if (expected_types.size() == 0) begin
          report_mismatch($sformatf("unexpected result type=%0d queued=%0b",
                                    result.chosen_type, result.from_queue));
        end else begin
          want = expected_types.pop_front();
          if (result.chosen_type !== want.chosen_type)
            report_mismatch($sformatf("chosen_type %0d, want %0d",
                                      result.chosen_type, want.chosen_type));
          if (result.from_queue !== want.from_queue)
            report_mismatch($sformatf("from_queue %0b, want %0b",
                                      result.from_queue, want.from_queue));
        end
      end
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic issue_request(input in_t j, input int gap, input bit pin = 1'b0,
                               input out_t want = '0);
    @(negedge clk);
    job       = j;
    start     = 1'b1;
    pin_valid = pin;
    pin_value = want;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drains outstanding results, then lets an enqueue in flight finish.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (expected_types.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic void add_req(input logic cmd, input logic [2:0] t,
                                  input bit pin = 1'b0, input out_t want = '0);
    row_t r;
    r         = '0;
    r.item    = {cmd, t};
    r.pinned  = pin;
    r.want    = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] data);
    row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.data    = data;
    directed_rows.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Builds one 12-bit slot: mostly short counts so the walk keeps moving.
  function automatic logic [SLOT_W-1:0] random_slot();
    logic [COUNT_W-1:0] count;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 60)      count = COUNT_W'($urandom_range(0, 3));
    else if (r < 90) count = COUNT_W'($urandom_range(4, 12));
    else             count = COUNT_W'($urandom_range(200, 255));
    return {1'($urandom_range(0, 1)), count, 3'($urandom_range(0, 7))};
  endfunction

  task automatic setup_phase(input int phase);
    logic [3:0]  len;
    logic [31:0] pair;
    wait_idle();
    if (phase == 0)      len = 4'd1;
    else if (phase == 1) len = 4'd15;
    else if (phase == 2) len = 4'd8;
    else                 len = 4'($urandom_range(0, 15));
    write_reg(REG_SLOT_LENGTH, {28'($urandom), len});
    for (int i = 0; i < SLOT_REGS; i++) begin
      if (phase == 0)      pair = {8'($urandom), 24'h000000};
      else if (phase == 1) pair = 32'hFFFF_FFFF;
      else                 pair = {8'($urandom), random_slot(), random_slot()};
      write_reg(REG_SLOTS_A + 3'(i), pair);
    end
  endtask

  initial begin
    in_t j;
    int  enq_pct;
    bit  no_idle;
    rst            = 1'b1;
    start          = 1'b0;
    job            = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pin_valid      = 1'b0;
    pin_value      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    sched_reset();

    // Directed table: reset state, queue priority, length and count corners.
    add_req(CMD_SEND, 3'd0, 1'b1, out_t'{3'd0, 1'b0});
    add_req(CMD_ENQUEUE, 3'd7);
    add_req(CMD_SEND, 3'd5, 1'b1, out_t'{3'd0, 1'b0});
    add_cfg(REG_SLOT_LENGTH, 32'd2);
    add_cfg(REG_SLOTS_A, 32'h0001_5807);
    add_req(CMD_SEND, 3'd0, 1'b1, out_t'{3'd7, 1'b1});
    add_req(CMD_SEND, 3'd7);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_ENQUEUE, 3'd0);
    add_req(CMD_ENQUEUE, 3'd3);
    add_req(CMD_ENQUEUE, 3'd3);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_cfg(REG_SLOT_LENGTH, 32'd0);
    add_cfg(REG_SLOTS_A, 32'hFFFF_FFFA);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_cfg(REG_SLOT_LENGTH, 32'hFFFF_FFFF);
    add_cfg(REG_SLOTS_B, 32'h00FF_FFFF);
    add_cfg(REG_SLOTS_C, 32'h0000_0000);
    add_cfg(REG_SLOTS_D, 32'h005A_38A5);
    // Counter now above the new count: the next send ends the slot.
    add_cfg(REG_SLOTS_A, 32'h0000_F00E);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_cfg(REG_SPARE_LO, 32'hFFFF_FFFF);
    add_cfg(REG_SPARE_HI, 32'h1234_5678);
    // Length drops below the current index; the walk wraps at slot end.
    add_cfg(REG_SLOT_LENGTH, 32'd2);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);
    add_req(CMD_SEND, 3'd0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
      end else begin
        issue_request(directed_rows[i].item, pick_gap(), directed_rows[i].pinned,
                      directed_rows[i].want);
      end
    end

    // Random phases, each under a new slot table and enqueue mix.
    for (int p = 0; p < PHASES; p++) begin
      setup_phase(p);
      enq_pct = $urandom_range(10, 60);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        j.command      = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_SEND;
        j.request_type = TYPE_W'($urandom_range(0, 7));
        issue_request(j, no_idle ? 0 : pick_gap());
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_types.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
